// ===== rtl/dkt_pkg.sv =====
// Shared types and constants for the date-keyed table range query block.
// No dependencies; imported by dkt_cell and date_keyed_table_range_query.
`timescale 1ns / 1ps
`default_nettype none

package dkt_pkg;

    localparam int DATE_W   = 25;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int OUT_PAY_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_EXACT = 2'd1,
        OP_RANGE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 2'd0,
        ST_FULL     = 2'd1,
        ST_MATCH    = 2'd2,
        ST_NO_MATCH = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;   // sorted insert of the incoming entry
        logic rot;   // rotate the chain one place toward cell 0
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/dkt_cell.sv =====
// One cell of the sorted entry chain: holds a date and payload, and either
// shifts in from its lower neighbor on insert or from its upper one on rotate.
// Depends on dkt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dkt_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                      i_clk,
    input  wire dkt_pkg::t_cell_ctl        i_ctl,
    input  wire logic                      i_occ,
    input  wire logic [24:0]               i_new_date,
    input  wire logic [PAYLOAD_BITS-1:0]   i_new_pay,
    input  wire logic                      i_prev_gt,
    input  wire logic [24:0]               i_prev_date,
    input  wire logic [PAYLOAD_BITS-1:0]   i_prev_pay,
    input  wire logic [24:0]               i_next_date,
    input  wire logic [PAYLOAD_BITS-1:0]   i_next_pay,
    output logic                           o_gt,
    output logic [24:0]                    o_date,
    output logic [PAYLOAD_BITS-1:0]        o_pay
);
    import dkt_pkg::*;

    logic [DATE_W-1:0]       r_date;
    logic [DATE_W-1:0]       n_date;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [PAYLOAD_BITS-1:0] n_pay;
    logic                    w_gt;

    // An empty cell or one with a later date lies past the insert point,
    // so equal dates stay ahead of the new entry.
    assign w_gt = !i_occ || (r_date > i_new_date);

    always_comb begin
        priority if (i_ctl.rot) begin
            n_date = i_next_date;
            n_pay  = i_next_pay;
        end else if (i_ctl.ins && w_gt && i_prev_gt) begin
            n_date = i_prev_date;
            n_pay  = i_prev_pay;
        end else if (i_ctl.ins && w_gt) begin
            n_date = i_new_date;
            n_pay  = i_new_pay;
        end else begin
            n_date = r_date;
            n_pay  = r_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_date <= n_date;
        r_pay  <= n_pay;
    end

    assign o_gt   = w_gt;
    assign o_date = r_date;
    assign o_pay  = r_pay;

endmodule

`default_nettype wire

// ===== rtl/date_keyed_table_range_query.sv =====
// Date-keyed table with exact and range queries. Entries are kept sorted by
// date in a chain of CAPACITY cells; an add inserts the new entry after the
// last entry of equal or earlier date, so equal dates keep insertion order.
// A query rotates the whole chain past cell 0, one cell per cycle while the
// output is not stalled; matches leave in ascending date order, and a query
// with no match gives one no-match result at the end of the rotation. The
// block takes a new input transfer only when idle and the output register
// can be loaded. Depends on dkt_pkg and dkt_cell.
`timescale 1ns / 1ps
`default_nettype none

module date_keyed_table_range_query #(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_opcode,
    input  wire logic [24:0]                 i_key_low,
    input  wire logic [24:0]                 i_key_high,
    input  wire logic [31:0]                 i_new_payload,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_status,
    output logic [24:0]                      o_found_date,
    output logic [31:0]                      o_found_payload,
    output logic                             o_last
);
    import dkt_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NXT = (CAPACITY > 1) ? 1 : 0;

    t_state                  r_state;
    t_state                  n_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [IW-1:0]           r_idx;
    logic [IW-1:0]           n_idx;
    logic                    r_found;
    logic                    n_found;
    logic [DATE_W-1:0]       r_lo;
    logic [DATE_W-1:0]       n_lo;
    logic [DATE_W-1:0]       r_hi;
    logic [DATE_W-1:0]       n_hi;

    logic                    r_out_valid;
    logic                    n_out_valid;
    t_status                 r_status;
    t_status                 n_status;
    logic [DATE_W-1:0]       r_date;
    logic [DATE_W-1:0]       n_date;
    logic [OUT_PAY_W-1:0]    r_pay;
    logic [OUT_PAY_W-1:0]    n_pay;
    logic                    r_last;
    logic                    n_last;

    t_cell_ctl               w_ctl;
    t_op                     w_op;
    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_full;
    logic [PAYLOAD_BITS-1:0] w_new_pay;
    logic [OUT_PAY_W-1:0]    w_head_pay;
    logic [CW-1:0]           w_idx_ext;
    logic [CW-1:0]           w_next_idx;
    logic                    w_match0;
    logic                    w_match1;
    logic                    w_last_step;

    logic [DATE_W-1:0]       w_cdate [CAPACITY];
    logic [PAYLOAD_BITS-1:0] w_cpay  [CAPACITY];
    logic                    w_cgt   [CAPACITY];

    assign w_op       = t_op'(i_opcode);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(CAPACITY));

    assign w_ctl.ins = w_accept && (w_op == OP_ADD) && !w_full;
    assign w_ctl.rot = (r_state == S_SCAN) && w_out_free;

    generate
        if (PAYLOAD_BITS <= OUT_PAY_W) begin : g_narrow
            assign w_new_pay  = i_new_payload[PAYLOAD_BITS-1:0];
            assign w_head_pay = {{(OUT_PAY_W-PAYLOAD_BITS){1'b0}}, w_cpay[0]};
        end else begin : g_wide
            assign w_new_pay  = {{(PAYLOAD_BITS-OUT_PAY_W){1'b0}}, i_new_payload};
            assign w_head_pay = w_cpay[0][OUT_PAY_W-1:0];
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                    w_prev_gt;
            logic [DATE_W-1:0]       w_prev_date;
            logic [PAYLOAD_BITS-1:0] w_prev_pay;
            logic                    w_occ;

            assign w_occ = (CW'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign w_prev_gt   = 1'b0;
                assign w_prev_date = '0;
                assign w_prev_pay  = '0;
            end else begin : g_body
                assign w_prev_gt   = w_cgt[gi-1];
                assign w_prev_date = w_cdate[gi-1];
                assign w_prev_pay  = w_cpay[gi-1];
            end

            dkt_cell #(
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ),
                .i_new_date  (i_key_low),
                .i_new_pay   (w_new_pay),
                .i_prev_gt   (w_prev_gt),
                .i_prev_date (w_prev_date),
                .i_prev_pay  (w_prev_pay),
                .i_next_date (w_cdate[(gi + 1) % CAPACITY]),
                .i_next_pay  (w_cpay[(gi + 1) % CAPACITY]),
                .o_gt        (w_cgt[gi]),
                .o_date      (w_cdate[gi]),
                .o_pay       (w_cpay[gi])
            );
        end
    endgenerate

    // The table is sorted, so matches are contiguous: the current match is
    // the last one when the next entry in the chain does not match.
    assign w_idx_ext   = CW'(r_idx);
    assign w_next_idx  = w_idx_ext + CW'(1);
    assign w_match0    = (w_idx_ext < r_count) && (w_cdate[0] >= r_lo) &&
                         (w_cdate[0] <= r_hi);
    assign w_match1    = (w_next_idx < r_count) && (w_cdate[NXT] >= r_lo) &&
                         (w_cdate[NXT] <= r_hi);
    assign w_last_step = (r_idx == IW'(CAPACITY - 1));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_found     = r_found;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_date      = r_date;
        n_pay       = r_pay;
        n_last      = r_last;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_ADD: begin
                            n_out_valid = 1'b1;
                            n_date      = '0;
                            n_pay       = '0;
                            n_last      = 1'b1;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_ADDED;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_EXACT, OP_RANGE: begin
                            n_state = S_SCAN;
                            n_idx   = '0;
                            n_found = 1'b0;
                            n_lo    = i_key_low;
                            n_hi    = (w_op == OP_EXACT) ? i_key_low : i_key_high;
                        end
                        OP_NONE: begin
                            n_out_valid = 1'b1;
                            n_status    = ST_NO_MATCH;
                            n_date      = '0;
                            n_pay       = '0;
                            n_last      = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_ctl.rot) begin
                    n_idx = r_idx + IW'(1);
                    priority if (w_match0) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_MATCH;
                        n_date      = w_cdate[0];
                        n_pay       = w_head_pay;
                        n_last      = !w_match1;
                        n_found     = 1'b1;
                    end else if (w_last_step && !r_found) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_NO_MATCH;
                        n_date      = '0;
                        n_pay       = '0;
                        n_last      = 1'b1;
                    end else begin
                        // Nothing to report this step; the output register only drains.
                        n_found = r_found;
                    end
                    if (w_last_step) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_status <= n_status;
        r_date   <= n_date;
        r_pay    <= n_pay;
        r_last   <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found_date    = r_date;
    assign o_found_payload = r_pay;
    assign o_last          = r_last;

endmodule

`default_nettype wire

// ===== bench/date_keyed_table_range_query_test.sv =====
// Self-checking testbench for the date-keyed table range query block.
// Holds a sorted copy of the table, predicts every result transfer and checks it.
// Depends on dkt_pkg and date_keyed_table_range_query.
`timescale 1ns / 1ps

module date_keyed_table_range_query_test;
    import dkt_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int PAYLOAD_BITS   = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int STALL_HOLD     = 400;
    localparam int RANDOM_ITEMS   = 480;
    localparam logic [24:0] DATE_MAX = '1;

    typedef struct {
        logic [1:0]  status;
        logic [24:0] date;
        logic [31:0] payload;
        logic        is_last;
    } t_lookup_result;

    // Keeps the table sorted by date; a new entry goes after every entry of equal
    // or earlier date, so a plain scan yields ascending order with ties in
    // insertion order.
    class table_scoreboard;
        logic [24:0]    dates[$];
        logic [31:0]    payloads[$];
        t_lookup_result expected_q[$];
        int errors, n_items, n_added, n_full, n_results, n_matches, n_nomatch;

        function int fill();
            return dates.size();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_single(logic [1:0] status);
            t_lookup_result res;
            res = '{status, 25'd0, 32'd0, 1'b1};
            expected_q = {expected_q, res};
        endfunction

        function void note_item(t_op op, logic [24:0] lo, logic [24:0] hi,
                                logic [31:0] pay);
            t_lookup_result hits[$];
            t_lookup_result res;
            logic [63:0] stored;
            int pos;
            n_items++;
            case (op)
                OP_ADD: begin
                    if (dates.size() >= CAPACITY) begin
                        push_single(ST_FULL);
                    end else begin
                        pos = dates.size();
                        for (int i = 0; i < dates.size(); i++) begin
                            if (dates[i] > lo) begin
                                pos = i;
                                break;
                            end
                        end
                        stored = {32'd0, pay} & ((64'd1 << PAYLOAD_BITS) - 64'd1);
                        dates.insert(pos, lo);
                        payloads.insert(pos, stored[31:0]);
                        push_single(ST_ADDED);
                    end
                end
                OP_EXACT, OP_RANGE: begin
                    if (op == OP_EXACT)
                        hi = lo;
                    for (int i = 0; i < dates.size(); i++) begin
                        if (dates[i] >= lo && dates[i] <= hi) begin
                            res = '{ST_MATCH, dates[i], payloads[i], 1'b0};
                            hits = {hits, res};
                        end
                    end
                    if (hits.size() == 0) begin
                        push_single(ST_NO_MATCH);
                    end else begin
                        hits[hits.size() - 1].is_last = 1'b1;
                        expected_q = {expected_q, hits};
                    end
                end
                default: push_single(ST_NO_MATCH);
            endcase
        endfunction

        function void check_result(logic [1:0] status, logic [24:0] date,
                                   logic [31:0] payload, logic is_last);
            t_lookup_result exp_res;
            n_results++;
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected: status %0d date %0h",
                       status, date);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            case (status)
                ST_ADDED:    n_added++;
                ST_FULL:     n_full++;
                ST_MATCH:    n_matches++;
                default:     n_nomatch++;
            endcase
            if (status !== exp_res.status) begin
                $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
                errors++;
            end
            if (date !== exp_res.date) begin
                $error("found_date mismatch: expected %h, actual %h", exp_res.date, date);
                errors++;
            end
            if (payload !== exp_res.payload) begin
                $error("found_payload mismatch: expected %h, actual %h",
                       exp_res.payload, payload);
                errors++;
            end
            if (is_last !== exp_res.is_last) begin
                $error("last mismatch: expected %0d, actual %0d", exp_res.is_last, is_last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode = OP_NONE;
    logic [24:0] i_key_low = '0;
    logic [24:0] i_key_high = '0;
    logic [31:0] i_new_payload = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [24:0] o_found_date;
    logic [31:0] o_found_payload;
    logic        o_last;

    table_scoreboard sb = new();
    bit          calm = 1'b0;
    int          quiet_cycles = 0;
    logic [24:0] date_pool[8];

    date_keyed_table_range_query #(
        .CAPACITY    (CAPACITY),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_key_low      (i_key_low),
        .i_key_high     (i_key_high),
        .i_new_payload  (i_new_payload),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_found_date   (o_found_date),
        .o_found_payload(o_found_payload),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sender side: random gaps, then hold the item until the block takes it.
    task automatic send_item(input t_op op, input logic [24:0] lo, input logic [24:0] hi,
                             input logic [31:0] pay);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_key_low     <= lo;
        i_key_high    <= hi;
        i_new_payload <= pay;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_item(op, lo, hi, pay);
    endtask

    // Mostly dates from a small clustered pool so that ties and range hits are common.
    function automatic logic [24:0] pick_date();
        int r;
        r = $urandom_range(9);
        if (r <= 5)
            return date_pool[$urandom_range(7)];
        else if (r == 6)
            return 25'd0;
        else if (r == 7)
            return DATE_MAX;
        return 25'($urandom());
    endfunction

    task automatic send_random();
        t_op op;
        logic [24:0] lo, hi, tmp;
        int r;
        r = $urandom_range(99);
        if (sb.fill() < CAPACITY)
            op = r < 45 ? OP_ADD : r < 65 ? OP_EXACT : r < 92 ? OP_RANGE : OP_NONE;
        else
            op = r < 10 ? OP_ADD : r < 45 ? OP_EXACT : r < 92 ? OP_RANGE : OP_NONE;
        lo = pick_date();
        hi = pick_date();
        // Keep most ranges well ordered; the rest exercise an inverted range.
        if (op == OP_RANGE && lo > hi && $urandom_range(99) >= 15) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        send_item(op, lo, hi, $urandom());
    endtask

    // Receiver side: random stalls, one long hold-off so the block backs up.
    initial begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && sb.n_results >= 150) begin
                held = 1'b1;
                hold_left = STALL_HOLD;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 34);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_found_date, o_found_payload, o_last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("date_keyed_table_range_query verification failed");
            $finish;
        end
    end

    initial begin : main
        logic [24:0] base;
        base = 25'($urandom_range(33554000));
        for (int i = 0; i < 8; i++)
            date_pool[i] = base + 25'(i * 3);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, unused opcode, extremes, ties, inverted ranges.
        send_item(OP_EXACT, 25'd0, 25'd0, 32'd0);
        send_item(OP_RANGE, 25'd0, DATE_MAX, '1);
        send_item(OP_NONE, 25'd77, 25'd5, 32'h1234_5678);
        send_item(OP_ADD, 25'd0, 25'd0, 32'd0);
        send_item(OP_ADD, DATE_MAX, DATE_MAX, '1);
        send_item(OP_ADD, 25'd12345, 25'd0, 32'hAAAA_0001);
        send_item(OP_ADD, 25'd12345, DATE_MAX, 32'hAAAA_0002);
        send_item(OP_ADD, 25'd100, 25'd0, 32'h5555_5555);
        send_item(OP_ADD, 25'd12345, 25'd0, 32'hAAAA_0003);
        send_item(OP_EXACT, 25'd12345, 25'd0, '1);
        send_item(OP_EXACT, 25'd0, DATE_MAX, 32'd0);
        send_item(OP_EXACT, DATE_MAX, 25'd0, 32'd0);
        send_item(OP_EXACT, 25'd7, 25'd7, 32'd0);
        send_item(OP_RANGE, 25'd0, DATE_MAX, 32'd0);
        send_item(OP_RANGE, 25'd100, 25'd12345, 32'd0);
        send_item(OP_RANGE, 25'd12346, 25'd12345, 32'd0);
        send_item(OP_RANGE, DATE_MAX, 25'd0, 32'd0);
        send_item(OP_RANGE, 25'd100, 25'd100, 32'd0);
        send_item(OP_NONE, DATE_MAX, DATE_MAX, '1);
        send_item(OP_ADD, 25'h0AAAAAA, 25'h1555555, 32'hDEAD_BEEF);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 300 && n < 380);
            send_random();
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (CAPACITY + 10) @(posedge i_clk);

        $display("Run covered %0d input transfers and %0d result transfers:", sb.n_items,
                 sb.n_results);
        $display("  %0d adds, %0d refused on a full table, %0d matches, %0d empty answers.",
                 sb.n_added, sb.n_full, sb.n_matches, sb.n_nomatch);
        if (sb.errors == 0) begin
            $display("date_keyed_table_range_query verification clean");
        end else begin
            $display("date_keyed_table_range_query verification failed");
        end
        $finish;
    end

endmodule
